>>> rtl/smos_pkg.sv
// Package for the substring match block: opcodes, result kinds, transaction
// payload types and the control word broadcast to the match cells.
// No dependencies.
package smos_pkg;

    localparam int PATTERN_MAX_DEFAULT      = 64;
    localparam int STRING_COUNT_MAX_DEFAULT = 65536;
    localparam int INDEX_W                  = 16;

    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_END_SET = 2'd2
    } opcode_t;

    typedef enum logic {
        KIND_VERDICT = 1'b0,
        KIND_SUMMARY = 1'b1
    } result_kind_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] char_value;
        logic       last_char;
    } item_t;

    typedef struct packed {
        result_kind_t       result_kind;
        logic [INDEX_W-1:0] string_index;
        logic               matched;
        logic               any_found;
        logic               pattern_overflow;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       text;
        logic       clear;
        logic [7:0] char_value;
    } cell_ctrl_t;

endpackage

>>> rtl/smos_item_if.sv
// Input channel of the substring match block: valid/ready plus one item.
// Depends on smos_pkg.
interface smos_item_if;
    logic            valid;
    logic            ready;
    smos_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/smos_result_if.sv
// Result channel of the substring match block: valid/ready plus one result.
// Depends on smos_pkg.
interface smos_result_if;
    logic              valid;
    logic              ready;
    smos_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/smos_cell.sv
// One match cell: holds one pattern byte, its valid bit and one shift-and
// partial-match bit, fed from the previous cell. Depends on smos_pkg.
module smos_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  smos_pkg::cell_ctrl_t ctrl,
    input  logic                prev_valid,
    input  logic                prev_partial,
    input  logic                next_valid,
    output logic                chain_valid,
    output logic                valid,
    output logic                partial,
    output logic                hit
);
    import smos_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic       partial_reg;
    logic       partial_next;
    logic [7:0] byte_reg;
    logic       eff_valid;
    logic       write_en;
    logic       new_bit;

    always_comb
    begin
        eff_valid    = valid_reg && !(ctrl.load && ctrl.start);
        write_en     = ctrl.load && !eff_valid && prev_valid;
        new_bit      = prev_partial && valid_reg && (byte_reg == ctrl.char_value);
        valid_next   = valid_reg;
        if (ctrl.load)
        begin
            valid_next = eff_valid || write_en;
        end
        partial_next = partial_reg;
        if (ctrl.clear)
        begin
            partial_next = 1'b0;
        end
        else if (ctrl.text)
        begin
            partial_next = new_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            partial_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            partial_reg <= partial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            byte_reg <= ctrl.char_value;
        end
    end

    assign chain_valid = eff_valid;
    assign valid       = valid_reg;
    assign partial     = partial_reg;
    assign hit         = new_bit && !next_valid;

endmodule

>>> rtl/smos_out_buf.sv
// Two-entry result buffer (output register plus skid register) in front of
// the result channel. Depends on smos_pkg and smos_result_if.
module smos_out_buf
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  smos_pkg::result_t  push_data,
    output logic               room,
    smos_result_if.source      result
);
    import smos_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;
    logic    load_out;
    logic    load_skid;
    logic    move_skid;

    always_comb
    begin
        pop             = out_valid_reg && result.ready;
        move_skid       = pop && skid_valid_reg;
        load_out        = push && (!out_valid_reg || (pop && !skid_valid_reg));
        load_skid       = push && !load_out;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (load_out)
        begin
            out_data_reg <= push_data;
        end
        if (load_skid)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign room         = !skid_valid_reg;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

>>> rtl/substring_match_over_strings.sv
// Top level of the substring match block: control, string bookkeeping, the
// chain of match cells and the result buffer.
// Depends on smos_pkg, smos_item_if, smos_result_if, smos_cell, smos_out_buf.

// Shift-and substring search over a set of strings. Load the pattern one
// byte per transaction (last_char marks its end), then stream text bytes,
// marking each string end; every string end yields a verdict and an
// end-of-set transaction yields a summary. Each text byte updates all
// PATTERN_MAX cells of the chain at once, one cell per pattern byte.
// Results go through a two-entry buffer, so input is accepted every
// cycle until both entries hold results the sink has not taken.
module substring_match_over_strings
#(
    parameter int PATTERN_MAX      = smos_pkg::PATTERN_MAX_DEFAULT,
    parameter int STRING_COUNT_MAX = smos_pkg::STRING_COUNT_MAX_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    smos_item_if.sink     item,
    smos_result_if.source result
);
    import smos_pkg::*;

    localparam logic [INDEX_W-1:0] COUNT_LAST = INDEX_W'(STRING_COUNT_MAX - 1);

    cell_ctrl_t               ctrl;
    logic                     room;
    logic                     fire;
    logic                     res_valid;
    result_t                  res_data;
    logic [PATTERN_MAX:0]     chain_valid;
    logic [PATTERN_MAX:0]     valid_vec;
    logic [PATTERN_MAX-1:0]   partial_vec;
    logic [PATTERN_MAX-1:0]   hit_vec;
    logic                     hit_any;
    logic                     match_now;

    logic                     complete_reg;
    logic                     complete_next;
    logic                     match_reg;
    logic                     match_next;
    logic                     any_reg;
    logic                     any_next;
    logic                     overflow_reg;
    logic                     overflow_next;
    logic [INDEX_W-1:0]       count_reg;
    logic [INDEX_W-1:0]       count_next;

    assign chain_valid[0]          = 1'b1;
    assign valid_vec[PATTERN_MAX]  = 1'b0;

    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cell
        logic prev_partial;
        if (i == 0)
        begin : g_head
            assign prev_partial = 1'b1;
        end
        else
        begin : g_body
            assign prev_partial = partial_vec[i-1];
        end

        smos_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .prev_valid   (chain_valid[i]),
            .prev_partial (prev_partial),
            .next_valid   (valid_vec[i+1]),
            .chain_valid  (chain_valid[i+1]),
            .valid        (valid_vec[i]),
            .partial      (partial_vec[i]),
            .hit          (hit_vec[i])
        );
    end

    assign fire       = item.valid && room;
    assign item.ready = room;
    assign hit_any    = |hit_vec;
    assign match_now  = match_reg || hit_any || !valid_vec[0];

    always_comb
    begin
        ctrl            = '0;
        ctrl.char_value = item.data.char_value;
        res_valid       = 1'b0;
        res_data        = '0;
        complete_next   = complete_reg;
        match_next      = match_reg;
        any_next        = any_reg;
        overflow_next   = overflow_reg;
        count_next      = count_reg;
        if (fire)
        begin
            case (item.data.opcode)
                OP_PATTERN:
                begin
                    ctrl.load  = 1'b1;
                    ctrl.start = complete_reg;
                    if (complete_reg)
                    begin
                        ctrl.clear    = 1'b1;
                        overflow_next = 1'b0;
                        match_next    = 1'b0;
                    end
                    if (chain_valid[PATTERN_MAX])
                    begin
                        overflow_next = 1'b1;
                    end
                    complete_next = item.data.last_char;
                end
                OP_TEXT:
                begin
                    ctrl.text     = 1'b1;
                    complete_next = 1'b1;
                    if (item.data.last_char)
                    begin
                        ctrl.clear                = 1'b1;
                        any_next                  = any_reg || match_now;
                        match_next                = 1'b0;
                        res_valid                 = 1'b1;
                        res_data.result_kind      = KIND_VERDICT;
                        res_data.string_index     = count_reg;
                        res_data.matched          = match_now;
                        res_data.any_found        = any_reg || match_now;
                        res_data.pattern_overflow = overflow_reg;
                        if (count_reg < COUNT_LAST)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        match_next = match_now;
                    end
                end
                OP_END_SET:
                begin
                    ctrl.clear                = 1'b1;
                    match_next                = 1'b0;
                    any_next                  = 1'b0;
                    count_next                = '0;
                    res_valid                 = 1'b1;
                    res_data.result_kind      = KIND_SUMMARY;
                    res_data.string_index     = count_reg;
                    res_data.matched          = 1'b0;
                    res_data.any_found        = any_reg;
                    res_data.pattern_overflow = overflow_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            complete_reg <= 1'b1;
            match_reg    <= 1'b0;
            any_reg      <= 1'b0;
            overflow_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            complete_reg <= complete_next;
            match_reg    <= match_next;
            any_reg      <= any_next;
            overflow_reg <= overflow_next;
            count_reg    <= count_next;
        end
    end

    smos_out_buf u_out_buf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .room      (room),
        .result    (result)
    );

endmodule
